[rtl/mcr_pkg.sv]
// Shared widths, constants, types and tap table of the midpoint circle rasteriser.
`default_nettype none
package mcr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  localparam int OUT_BITS    = COORD_BITS + 2;
  localparam int DEC_BITS    = RADIUS_BITS + 7;
  localparam int COLOR_BITS  = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // pixels per job, and the tap counter width
  localparam int START_PIXELS = 4;
  localparam int STEP_PIXELS  = 8;
  localparam int TAP_BITS     = 3;

  // decision value constants
  localparam int DEC_INIT   = 5;
  localparam int DEC_DIAG   = 20;
  localparam int DEC_SIDE   = 12;
  localparam int POS_SHIFT  = 3;   // times 8
  localparam int RAD_SHIFT  = 2;   // times 4

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  // one unit of back-end work: the four or eight pixels of one item
  typedef struct packed {
    logic                   is_start;
    logic                   done;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
    logic [COLOR_BITS-1:0]  color;
  } job_t;

  // how one symmetric point is formed from (x, y)
  typedef struct packed {
    logic col_from_y;   // column offset is y instead of x
    logic col_neg;
    logic row_from_x;   // row offset is x instead of y
    logic row_neg;
  } tap_t;

  function automatic tap_t tap_sel(input logic [TAP_BITS-1:0] idx);
    tap_t t;
    unique case (idx)
      3'd0:    t = '{col_from_y: 1'b0, col_neg: 1'b0, row_from_x: 1'b0, row_neg: 1'b1};
      3'd1:    t = '{col_from_y: 1'b0, col_neg: 1'b0, row_from_x: 1'b0, row_neg: 1'b0};
      3'd2:    t = '{col_from_y: 1'b1, col_neg: 1'b0, row_from_x: 1'b1, row_neg: 1'b0};
      3'd3:    t = '{col_from_y: 1'b1, col_neg: 1'b0, row_from_x: 1'b1, row_neg: 1'b1};
      3'd4:    t = '{col_from_y: 1'b0, col_neg: 1'b1, row_from_x: 1'b0, row_neg: 1'b0};
      3'd5:    t = '{col_from_y: 1'b1, col_neg: 1'b1, row_from_x: 1'b1, row_neg: 1'b0};
      3'd6:    t = '{col_from_y: 1'b1, col_neg: 1'b1, row_from_x: 1'b1, row_neg: 1'b1};
      default: t = '{col_from_y: 1'b0, col_neg: 1'b1, row_from_x: 1'b0, row_neg: 1'b1};
    endcase
    return t;
  endfunction

  // a start emits the axis points: taps 0, 1, 2 and 5 with x = 0, y = R
  function automatic logic [TAP_BITS-1:0] start_tap(input logic [1:0] idx);
    logic [TAP_BITS-1:0] t;
    unique case (idx)
      2'd0:    t = 3'd0;
      2'd1:    t = 3'd1;
      2'd2:    t = 3'd2;
      default: t = 3'd5;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/mcr_front.sv]
// Front end: takes items, advances the octant state and issues pixel jobs.
`default_nettype none
module mcr_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_fire,
  input  wire                               opcode,
  input  wire  [mcr_pkg::COORD_BITS-1:0]    center_x,
  input  wire  [mcr_pkg::COORD_BITS-1:0]    center_y,
  input  wire  [mcr_pkg::RADIUS_BITS-1:0]   radius,
  input  wire  [mcr_pkg::COLOR_BITS-1:0]    pen_color,
  output logic                              push,
  output mcr_pkg::job_t                     push_job
);

  logic [mcr_pkg::RADIUS_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [mcr_pkg::RADIUS_BITS-1:0] pos_y_r, pos_y_nxt;
  logic [mcr_pkg::DEC_BITS-1:0]    dec_r, dec_nxt;
  logic [mcr_pkg::COORD_BITS-1:0]  cx_r, cx_nxt;
  logic [mcr_pkg::COORD_BITS-1:0]  cy_r, cy_nxt;
  logic [mcr_pkg::COLOR_BITS-1:0]  color_r, color_nxt;
  logic                            active_r, active_nxt;

  logic [mcr_pkg::DEC_BITS-1:0]    x_ext, y_ext, dec_diag, dec_side, dec_init;
  logic [mcr_pkg::RADIUS_BITS-1:0] x_new, y_new;
  logic                            step_ok;

  assign x_ext    = mcr_pkg::DEC_BITS'(pos_x_r);
  assign y_ext    = mcr_pkg::DEC_BITS'(pos_y_r);
  assign dec_diag = dec_r + ((x_ext - y_ext) << mcr_pkg::POS_SHIFT)
                    + mcr_pkg::DEC_BITS'(mcr_pkg::DEC_DIAG);
  assign dec_side = dec_r + (x_ext << mcr_pkg::POS_SHIFT)
                    + mcr_pkg::DEC_BITS'(mcr_pkg::DEC_SIDE);
  assign dec_init = mcr_pkg::DEC_BITS'(mcr_pkg::DEC_INIT)
                    - (mcr_pkg::DEC_BITS'(radius) << mcr_pkg::RAD_SHIFT);
  assign step_ok  = active_r && (pos_y_r > pos_x_r);
  assign x_new    = pos_x_r + 1'b1;
  assign y_new    = dec_r[mcr_pkg::DEC_BITS-1] ? pos_y_r : pos_y_r - 1'b1;

  always_comb begin
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    dec_nxt    = dec_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    active_nxt = active_r;
    push       = 1'b0;
    push_job   = '{is_start: 1'b0, done: (y_new <= x_new), cx: cx_r, cy: cy_r,
                   x: x_new, y: y_new, color: color_r};
    if (in_fire) begin
      if (mcr_pkg::opcode_t'(opcode) == mcr_pkg::OP_START) begin
        pos_x_nxt  = '0;
        pos_y_nxt  = radius;
        dec_nxt    = dec_init;
        cx_nxt     = center_x;
        cy_nxt     = center_y;
        color_nxt  = pen_color;
        active_nxt = (radius != '0);
        push       = 1'b1;
        push_job   = '{is_start: 1'b1, done: (radius == '0), cx: center_x,
                       cy: center_y, x: '0, y: radius, color: pen_color};
      end else if (step_ok) begin
        pos_x_nxt  = x_new;
        pos_y_nxt  = y_new;
        dec_nxt    = dec_r[mcr_pkg::DEC_BITS-1] ? dec_side : dec_diag;
        active_nxt = !(y_new <= x_new);
        push       = 1'b1;
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      dec_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else begin
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      dec_r    <= dec_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      color_r  <= color_nxt;
      active_r <= active_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/mcr_queue.sv]
// Short job queue between front and back end.
`default_nettype none
module mcr_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  mcr_pkg::job_t  push_job,
  output logic           full,
  input  wire            pop,
  output logic           q_valid,
  output mcr_pkg::job_t  q_job
);

  mcr_pkg::job_t                 mem_r [mcr_pkg::QUEUE_DEPTH];
  logic [mcr_pkg::PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [mcr_pkg::PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [mcr_pkg::CNT_BITS-1:0]  count_r, count_nxt;

  function automatic logic [mcr_pkg::PTR_BITS-1:0] ptr_inc(
    input logic [mcr_pkg::PTR_BITS-1:0] p);
    logic [mcr_pkg::PTR_BITS-1:0] n;
    if (p == mcr_pkg::PTR_BITS'(mcr_pkg::QUEUE_DEPTH - 1)) n = '0;
    else n = p + 1'b1;
    return n;
  endfunction

  assign full    = (count_r == mcr_pkg::CNT_BITS'(mcr_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/mcr_back.sv]
// Back end: walks the symmetric taps of a job, one pixel per cycle while the output is not stalled.
`default_nettype none
module mcr_back (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  q_valid,
  input  mcr_pkg::job_t                        q_job,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [mcr_pkg::OUT_BITS-1:0]  out_pixel_x,
  output logic signed [mcr_pkg::OUT_BITS-1:0]  out_pixel_y,
  output logic [mcr_pkg::COLOR_BITS-1:0]       out_pixel_color,
  output logic                                 out_last,
  output logic                                 out_done_res
);

  logic [mcr_pkg::TAP_BITS-1:0]   tap_cnt_r, tap_cnt_nxt;
  logic                           valid_r, valid_nxt;
  logic [mcr_pkg::OUT_BITS-1:0]   px_r, py_r;
  logic [mcr_pkg::COLOR_BITS-1:0] color_r;
  logic                           last_r, done_r;

  logic                           fire, is_last;
  logic [mcr_pkg::TAP_BITS-1:0]   tap_idx;
  mcr_pkg::tap_t                  tap;
  logic [mcr_pkg::OUT_BITS-1:0]   col_off, row_off, px_calc, py_calc;

  assign fire    = q_valid && (!valid_r || out_ready);
  assign is_last = q_job.is_start
                   ? (tap_cnt_r == mcr_pkg::TAP_BITS'(mcr_pkg::START_PIXELS - 1))
                   : (tap_cnt_r == mcr_pkg::TAP_BITS'(mcr_pkg::STEP_PIXELS - 1));
  assign pop     = fire && is_last;
  assign tap_idx = q_job.is_start ? mcr_pkg::start_tap(tap_cnt_r[1:0]) : tap_cnt_r;
  assign tap     = mcr_pkg::tap_sel(tap_idx);
  assign col_off = mcr_pkg::OUT_BITS'(tap.col_from_y ? q_job.y : q_job.x);
  assign row_off = mcr_pkg::OUT_BITS'(tap.row_from_x ? q_job.x : q_job.y);
  assign px_calc = tap.col_neg ? mcr_pkg::OUT_BITS'(q_job.cx) - col_off
                               : mcr_pkg::OUT_BITS'(q_job.cx) + col_off;
  assign py_calc = tap.row_neg ? mcr_pkg::OUT_BITS'(q_job.cy) - row_off
                               : mcr_pkg::OUT_BITS'(q_job.cy) + row_off;

  always_comb begin
    tap_cnt_nxt = tap_cnt_r;
    valid_nxt   = valid_r && !out_ready;
    if (fire) begin
      valid_nxt   = 1'b1;
      tap_cnt_nxt = is_last ? '0 : tap_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_cnt_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      tap_cnt_r <= tap_cnt_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      px_r    <= px_calc;
      py_r    <= py_calc;
      color_r <= q_job.color;
      last_r  <= is_last;
      done_r  <= q_job.done;
    end
  end

  assign out_valid       = valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = color_r;
  assign out_last        = last_r;
  assign out_done_res    = done_r;

  // a start job never runs past its four axis points
  a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_job.is_start |-> tap_cnt_r < mcr_pkg::TAP_BITS'(mcr_pkg::START_PIXELS))
    else $error("tap counter past end of start job");

  // the tap counter rests at zero between jobs
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> tap_cnt_r == '0)
    else $error("tap counter not cleared between jobs");

  // each non-final pixel moves the counter on by exactly one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !is_last |=> tap_cnt_r == $past(tap_cnt_r) + 1'b1)
    else $error("tap counter skipped");

endmodule
`default_nettype wire

[rtl/midpoint_circle_rasterizer_unit.sv]
// Top level of the midpoint circle outline rasteriser.
//
// Input channel (in_valid/in_ready): opcode OP_START latches centre, radius and
// colour and yields the four axis pixels; OP_STEP advances the octant one
// column and yields the eight symmetric pixels (none once the circle is done
// or when no circle is in progress).
// Output channel (out_valid/out_ready): one pixel per transfer, with out_last
// on the final pixel of an item and out_done_res on every pixel of the item
// that finished the circle. No clipping: coordinates are signed.
// Path: an item's jobs pass through the job queue, and each pixel is then held
// in the back end's output register before it can transfer. Throughput: one
// pixel per cycle from the single output register while the receiver is ready
// and jobs are queued, so a step item takes eight pixel transfers and a start
// four; the back end's tap walk sets this. The front end runs ahead through a
// two-entry job queue, so items are taken back to back until the queue fills.
// Reset (rst_n low, synchronous) clears the octant state, empties the queue
// and drops any pending pixel. When the receiver stalls, the output holds its
// pixel, the back end stops, and in_ready falls once the queue is full.
`default_nettype none
module midpoint_circle_rasterizer_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_opcode,
  input  wire  [mcr_pkg::COORD_BITS-1:0]       in_center_x,
  input  wire  [mcr_pkg::COORD_BITS-1:0]       in_center_y,
  input  wire  [mcr_pkg::RADIUS_BITS-1:0]      in_radius,
  input  wire  [mcr_pkg::COLOR_BITS-1:0]       in_pen_color,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [mcr_pkg::OUT_BITS-1:0]  out_pixel_x,
  output logic signed [mcr_pkg::OUT_BITS-1:0]  out_pixel_y,
  output logic [mcr_pkg::COLOR_BITS-1:0]       out_pixel_color,
  output logic                                 out_last,
  output logic                                 out_done_res
);

  logic          push, full, pop, q_valid, in_fire;
  mcr_pkg::job_t push_job, q_job;

  // front may take any item while the queue has room; a step that yields
  // nothing simply pushes no job
  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  mcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .opcode    (in_opcode),
    .center_x  (in_center_x),
    .center_y  (in_center_y),
    .radius    (in_radius),
    .pen_color (in_pen_color),
    .push      (push),
    .push_job  (push_job)
  );

  mcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  mcr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (q_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last),
    .out_done_res    (out_done_res)
  );

endmodule
`default_nettype wire
